>>> design/spq_pkg.sv
package spq_pkg;

  localparam int SPQ_CAPACITY = 16;

  localparam int TAG_W   = 8;
  localparam int PRIO_W  = 13;
  localparam int AGIL_W  = 8;
  localparam int GAIN_W  = 5;
  localparam int CLASS_W = 2;
  localparam int CNT_W   = 5;
  localparam int IDX_W   = 2;

  localparam logic [GAIN_W-1:0] AGILE_GAIN_RST  = GAIN_W'(15);
  localparam logic [GAIN_W-1:0] TANK_GAIN_RST   = GAIN_W'(8);
  localparam logic [GAIN_W-1:0] NORMAL_GAIN_RST = GAIN_W'(10);

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_AGILE  = 2'd0,
    CLASS_TANK   = 2'd1,
    CLASS_OTHER  = 2'd2,
    CLASS_SPARE  = 2'd3
  } class_e;

  typedef enum logic [IDX_W-1:0] {
    REG_AGILE_GAIN  = 2'd0,
    REG_TANK_GAIN   = 2'd1,
    REG_NORMAL_GAIN = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic               op;
    logic [TAG_W-1:0]   item_tag;
    logic [AGIL_W-1:0]  agility;
    logic [CLASS_W-1:0] item_class;
    logic               alive;
  } in_word_t;

  typedef struct packed {
    logic [TAG_W-1:0]  front_tag;
    logic [PRIO_W-1:0] front_priority;
    logic [CNT_W-1:0]  entry_count;
    logic              is_empty;
    logic              op_error;
  } out_word_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } slot_t;

  typedef struct packed {
    logic  push;
    logic  pop;
    slot_t fresh;
  } cell_ctl_t;

endpackage

>>> design/spq_gain.sv
module spq_gain (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr,
  input  logic [spq_pkg::IDX_W-1:0]   cfg_index,
  input  logic [spq_pkg::GAIN_W-1:0]  cfg_data,
  input  logic                        load,
  input  logic [spq_pkg::AGIL_W-1:0]  agility,
  input  logic [spq_pkg::CLASS_W-1:0] item_class,
  input  logic                        alive,
  output logic [spq_pkg::PRIO_W-1:0]  prio
);
  import spq_pkg::*;

  logic [GAIN_W-1:0] agile_gain;
  logic [GAIN_W-1:0] tank_gain;
  logic [GAIN_W-1:0] normal_gain;
  logic [GAIN_W-1:0] gain_sel;
  logic [PRIO_W-1:0] prio_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      agile_gain  <= AGILE_GAIN_RST;
      tank_gain   <= TANK_GAIN_RST;
      normal_gain <= NORMAL_GAIN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_AGILE_GAIN:  agile_gain  <= cfg_data;
        REG_TANK_GAIN:   tank_gain   <= cfg_data;
        REG_NORMAL_GAIN: normal_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (class_e'(item_class))
      CLASS_AGILE: gain_sel = agile_gain;
      CLASS_TANK:  gain_sel = tank_gain;
      default:     gain_sel = normal_gain;
    endcase
    prio_next = alive ? (PRIO_W'(agility) * PRIO_W'(gain_sel)) : '0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prio <= prio_next;
    end
  end

endmodule

>>> design/spq_cell.sv
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic               occ,
  input  logic               left_ge,
  input  spq_pkg::slot_t     left_slot,
  input  spq_pkg::slot_t     right_slot,
  output spq_pkg::slot_t     slot,
  output logic               ge
);
  import spq_pkg::*;

  // entry stays ahead of the new word when its priority is equal or higher
  assign ge = occ && (slot.prio >= ctl.fresh.prio);

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      slot <= right_slot;
    end else if (ctl.push && !ge) begin
      slot <= left_ge ? ctl.fresh : left_slot;
    end
  end

endmodule

>>> design/sorted_priority_queue.sv
// Channel  Ports                                    Handshake
// cmd      start, busy, cmd                         taken when start && !busy
// result   done, result                             one-cycle strobe, no stall
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data taken when valid && ready
//
// A taken word is registered with its computed priority; the cell row, count and
// error flag then update as done is raised, and result is valid while done is high.
// busy is high while a taken word is pending, so words never overlap;
// this is set by the priority multiply register followed by the cell row update.
// All cells compare and shift in the same cycle; capacity does not change timing.
// Synchronous reset empties the queue and loads the default gains.
// cfg_ready is always high; the result side cannot stall the block.
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  spq_pkg::in_word_t          cmd,
  output logic                       done,
  output spq_pkg::out_word_t         result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [spq_pkg::IDX_W-1:0]  cfg_index,
  input  logic [spq_pkg::GAIN_W-1:0] cfg_data
);
  import spq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic              accept;
  logic              pend;
  logic              item_op;
  logic [TAG_W-1:0]  item_tag;
  logic [PRIO_W-1:0] item_prio;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              err;
  logic              err_next;
  logic              full;
  logic              empty;
  cell_ctl_t         ctl;
  slot_t             slots [CAPACITY];
  logic [CAPACITY-1:0] ge_vec;

  assign accept    = start && !busy;
  assign busy      = pend;
  assign cfg_ready = 1'b1;
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);

  spq_gain u_gain (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .load       (accept),
    .agility    (cmd.agility),
    .item_class (cmd.item_class),
    .alive      (cmd.alive),
    .prio       (item_prio)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      item_op  <= cmd.op;
      item_tag <= cmd.item_tag;
    end
  end

  always_comb begin
    ctl.push        = pend && (item_op == OP_ENQ) && !full;
    ctl.pop         = pend && (item_op == OP_DEQ) && !empty;
    ctl.fresh.tag   = item_tag;
    ctl.fresh.prio  = item_prio;
    count_next      = count;
    err_next        = err;
    if (pend) begin
      err_next = (item_op == OP_ENQ) ? full : empty;
      if (ctl.push) begin
        count_next = count + CW'(1);
      end else if (ctl.pop) begin
        count_next = count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
      err   <= 1'b0;
    end else begin
      pend  <= accept;
      done  <= pend;
      count <= count_next;
      err   <= err_next;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (count > CW'(i)),
      .left_ge    ((i == 0) ? 1'b1 : ge_vec[(i == 0) ? 0 : i - 1]),
      .left_slot  (slots[(i == 0) ? 0 : i - 1]),
      .right_slot (slots[(i == CAPACITY - 1) ? i : i + 1]),
      .slot       (slots[i]),
      .ge         (ge_vec[i])
    );
  end

  always_comb begin
    result.front_tag      = empty ? '0 : slots[0].tag;
    result.front_priority = empty ? '0 : slots[0].prio;
    result.entry_count    = CNT_W'(count);
    result.is_empty       = empty;
    result.op_error       = err;
  end

  a_strobe: assert property (@(posedge clk) disable iff (rst) pend |=> done)
    else $error("result strobe missing");
  a_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("count above capacity");
  a_push: assert property (@(posedge clk) disable iff (rst)
    ctl.push |=> count == $past(count) + CW'(1))
    else $error("count not raised on insert");
  a_err: assert property (@(posedge clk) disable iff (rst)
    done && result.op_error |-> count == $past(count))
    else $error("state changed on error");

endmodule
